>>> rtl/sm4_pkg.sv
// ----------------------------------------------------------------------------
// sm4_pkg
// Shared types, constants and round functions for the SM4 CBC cipher.
// ----------------------------------------------------------------------------
package sm4_pkg;

    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
        logic        first_block;
    } t_in_item;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_core_state;

    // register indexes
    localparam logic [2:0] REG_KEY_HIGH = 3'd0;
    localparam logic [2:0] REG_KEY_LOW  = 3'd1;
    localparam logic [2:0] REG_IV_HIGH  = 3'd2;
    localparam logic [2:0] REG_IV_LOW   = 3'd3;
    localparam logic [2:0] REG_DECRYPT  = 3'd4;

    localparam logic [127:0] FK = 128'ha3b1bac6_56aa3350_677d9197_b27022dc;

    localparam logic [7:0] SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    function automatic logic [31:0] sm4_tau(input logic [31:0] x);
        sm4_tau = {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

    // byte j of CK[i] is (4i+j)*7 mod 256
    function automatic logic [31:0] sm4_ck(input logic [4:0] i);
        logic [7:0] b0;
        b0 = {1'b0, i, 2'b00} * 8'd7;
        sm4_ck = {b0, b0 + 8'd7, b0 + 8'd14, b0 + 8'd21};
    endfunction

endpackage

>>> rtl/sm4_round.sv
// ----------------------------------------------------------------------------
// sm4_round
// Shared round unit: S-box layer and linear transform, data or key flavor.
// ----------------------------------------------------------------------------
module sm4_round
    import sm4_pkg::*;
(
    input  logic [127:0] i_state,
    input  logic [31:0]  i_rk,
    input  logic         i_key_sched,
    output logic [127:0] o_state
);
    logic [31:0] w_t;
    logic [31:0] w_l;

    always_comb begin
        w_t = sm4_tau(i_state[95:64] ^ i_state[63:32] ^ i_state[31:0] ^ i_rk);
        if (i_key_sched) begin
            w_l = w_t ^ rotl(w_t, 13) ^ rotl(w_t, 23);
        end else begin
            w_l = w_t ^ rotl(w_t, 2) ^ rotl(w_t, 10) ^ rotl(w_t, 18) ^ rotl(w_t, 24);
        end
        o_state = {i_state[95:0], i_state[127:96] ^ w_l};
    end
endmodule

>>> rtl/sm4_cbc_cipher.sv
// ----------------------------------------------------------------------------
// sm4_cbc_cipher
// SM4 block cipher, CBC mode, APB configuration.
// ----------------------------------------------------------------------------
// Rounds: 32 rounds from input transfer to result valid, one round per cycle;
//   key expansion runs after a key write or reset, before the next input.
// Flow: a new block is taken only after the previous result is taken, so
//   output stalls hold input; one shared round unit also runs key expansion.
// Reset: synchronous active low; control, key, IV and chain registers clear,
//   then the all-zero key is expanded before the first input is taken.
module sm4_cbc_cipher
    import sm4_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_item    i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    t_core_state r_state, n_state;
    logic [127:0] r_key, r_iv, r_chain, r_x;
    logic         r_dec, r_kexp, r_kpend;
    logic [5:0]   r_cnt;
    logic [31:0]  r_rk [32];
    logic [127:0] w_round;
    logic [31:0]  w_rk;
    logic         w_wr;
    logic [2:0]   w_idx;
    logic [127:0] w_chain, w_x0, w_res;
    // previous chain for decrypt xor
    logic [127:0] r_prev;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[5:3];

    always_comb begin
        unique case (w_idx)
            REG_KEY_HIGH: prdata = r_key[127:64];
            REG_KEY_LOW:  prdata = r_key[63:0];
            REG_IV_HIGH:  prdata = r_iv[127:64];
            REG_IV_LOW:   prdata = r_iv[63:0];
            REG_DECRYPT:  prdata = {63'd0, r_dec};
            default:      prdata = 64'd0;
        endcase
    end

    // round key: key expansion uses CK, data rounds read the key store
    always_comb begin
        if (r_kexp) begin
            w_rk = sm4_ck(r_cnt[4:0]);
        end else if (r_dec) begin
            w_rk = r_rk[5'd31 - r_cnt[4:0]];
        end else begin
            w_rk = r_rk[r_cnt[4:0]];
        end
    end

    sm4_round u_round (
        .i_state     (r_x),
        .i_rk        (w_rk),
        .i_key_sched (r_kexp),
        .o_state     (w_round)
    );

    assign w_chain = i_data.first_block ? r_iv : r_chain;
    assign w_x0    = r_dec ? {i_data.block_high, i_data.block_low}
                           : ({i_data.block_high, i_data.block_low} ^ w_chain);
    // output word order reversal
    assign w_res   = {r_x[31:0], r_x[63:32], r_x[95:64], r_x[127:96]};

    assign o_ready = (r_state == ST_IDLE) && !r_kexp && !r_kpend;
    assign o_valid = (r_state == ST_DONE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_valid && o_ready) n_state = ST_RUN;
            ST_RUN:  if (r_cnt == 6'd31) n_state = ST_DONE;
            ST_DONE: if (i_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_key   <= '0;
            r_iv    <= '0;
            r_chain <= '0;
            r_dec   <= 1'b0;
            r_kexp  <= 1'b0;
            r_kpend <= 1'b1;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (w_wr) begin
                unique case (w_idx)
                    REG_KEY_HIGH: begin r_key[127:64] <= pwdata; r_kpend <= 1'b1; end
                    REG_KEY_LOW:  begin r_key[63:0] <= pwdata; r_kpend <= 1'b1; end
                    REG_IV_HIGH:  r_iv[127:64] <= pwdata;
                    REG_IV_LOW:   r_iv[63:0] <= pwdata;
                    REG_DECRYPT:  r_dec <= pwdata[0];
                    default: ;
                endcase
            end
            if (r_kpend && !w_wr && !r_kexp && r_state == ST_IDLE) begin
                // start key expansion
                r_kpend <= 1'b0;
                r_kexp  <= 1'b1;
                r_cnt   <= '0;
                r_x     <= r_key ^ FK;
            end else if (r_kexp) begin
                r_rk[r_cnt[4:0]] <= w_round[31:0];
                r_x   <= w_round;
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) r_kexp <= 1'b0;
            end else if (r_state == ST_IDLE && i_valid && o_ready) begin
                r_x   <= w_x0;
                r_cnt <= '0;
                if (r_dec) r_chain <= {i_data.block_high, i_data.block_low};
                else       r_chain <= w_chain;
            end else if (r_state == ST_RUN) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_x <= {w_round[31:0], w_round[63:32], w_round[95:64], w_round[127:96]};
                end else begin
                    r_x <= w_round;
                end
            end
            if (r_state == ST_RUN && r_cnt == 6'd31 && !r_dec) begin
                r_chain <= {w_round[31:0], w_round[63:32], w_round[95:64], w_round[127:96]};
            end
        end
    end

    // r_x holds the reversed result in ST_DONE; undo the w_res reversal in both modes, xor r_prev for decrypt
    always_comb begin
        o_data = r_dec ? ({w_res[31:0], w_res[63:32], w_res[95:64], w_res[127:96]} ^ r_prev)
                       : {w_res[31:0], w_res[63:32], w_res[95:64], w_res[127:96]};
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid && o_ready) r_prev <= w_chain;
    end

`ifndef NO_ASSERTIONS
    a_no_kexp_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kexp |-> r_state == ST_IDLE) else $error("key expansion during block");
    a_done_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_cnt == 6'd31) |=> o_valid) else $error("missing result");
    a_not_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_ready) else $error("ready while busy");
`endif
endmodule
